@@ design/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and round functions for the AES-256 CBC block.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS    = 14;
    localparam int KEY_AW    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 64;

    typedef logic [KEY_AW-1:0] kaddr_t;
    typedef logic [127:0]      blk_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_IV_HI  = 3'd4,
        REG_IV_LO  = 3'd5,
        REG_MODE   = 3'd6,
        REG_UNUSED = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        final_block;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        final_out;
    } out_item_t;

    typedef struct packed {
        logic   we;
        kaddr_t enc_addr;
        kaddr_t dec_addr;
        blk_t   enc_key;
        blk_t   dec_key;
    } ks_wr_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TABLE[8*(255 - int'(b)) +: 8];
    endfunction

    function automatic logic [7:0] inv_affine(input logic [7:0] b);
        return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] b);
        return inv_affine(sbox(inv_affine(b)));
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input blk_t s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic blk_t mix_fwd(input blk_t s);
        blk_t r;
        logic [7:0] a0, a1, a2, a3;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            r[127-32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            r[119-32*c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            r[111-32*c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            r[103-32*c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return r;
    endfunction

    function automatic blk_t mix_inv(input blk_t s);
        blk_t r;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                a[j]  = get_byte(s, 4*c+j);
                x2[j] = xt(a[j]);
                x4[j] = xt(x2[j]);
                m9[j] = xt(x4[j]) ^ a[j];
                mb[j] = m9[j] ^ x2[j];
                md[j] = m9[j] ^ x4[j];
                me[j] = xt(x4[j]) ^ x4[j] ^ x2[j];
            end
            r[127-32*c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            r[119-32*c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            r[111-32*c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            r[103-32*c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return r;
    endfunction

    function automatic blk_t round_fn(input blk_t s, input logic dec, input logic last);
        blk_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                if (dec) begin
                    t[127-8*(4*c+j) -: 8] = inv_sbox(get_byte(s, 4*((c-j+4)%4)+j));
                end else begin
                    t[127-8*(4*c+j) -: 8] = sbox(get_byte(s, 4*((c+j)%4)+j));
                end
            end
        end
        if (last) begin
            return t;
        end
        return dec ? mix_inv(t) : mix_fwd(t);
    endfunction

endpackage

@@ design/aes_ksched.sv @@
// ----------------------------------------------------------------------------
// AES key scheduler
// Produces one round key per cycle and writes the forward and equivalent
// inverse keys into the key memory.
// ----------------------------------------------------------------------------
module aes_ksched (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [255:0]    key,
    output aes_pkg::ks_wr_t wr,
    output logic            done
);
    import aes_pkg::*;

    logic         busy_reg, busy_next;
    kaddr_t       cnt_reg, cnt_next;
    logic [255:0] win_reg, win_next;
    logic [7:0]   rcon_reg, rcon_next;
    blk_t         rk;
    blk_t         gen;
    logic [31:0]  last_w, t, w0, w1, w2, w3;

    always_comb begin
        last_w = win_reg[31:0];
        if (!cnt_reg[0]) begin
            t = {sbox(last_w[23:16]) ^ rcon_reg, sbox(last_w[15:8]),
                 sbox(last_w[7:0]), sbox(last_w[31:24])};
        end else begin
            t = {sbox(last_w[31:24]), sbox(last_w[23:16]),
                 sbox(last_w[15:8]), sbox(last_w[7:0])};
        end
        w0  = win_reg[255:224] ^ t;
        w1  = win_reg[223:192] ^ w0;
        w2  = win_reg[191:160] ^ w1;
        w3  = win_reg[159:128] ^ w2;
        gen = {w0, w1, w2, w3};
        if (cnt_reg == kaddr_t'(0)) begin
            rk = win_reg[255:128];
        end else if (cnt_reg == kaddr_t'(1)) begin
            rk = win_reg[127:0];
        end else begin
            rk = gen;
        end
    end

    always_comb begin
        wr.we       = busy_reg;
        wr.enc_addr = cnt_reg;
        wr.dec_addr = kaddr_t'(ROUNDS) - cnt_reg;
        wr.enc_key  = rk;
        if (cnt_reg == kaddr_t'(0) || cnt_reg == kaddr_t'(ROUNDS)) begin
            wr.dec_key = rk;
        end else begin
            wr.dec_key = mix_inv(rk);
        end
        done = busy_reg && (cnt_reg == kaddr_t'(ROUNDS));
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        win_next  = win_reg;
        rcon_next = rcon_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            win_next  = key;
            rcon_next = 8'h01;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + kaddr_t'(1);
            if (cnt_reg == kaddr_t'(ROUNDS)) begin
                busy_next = 1'b0;
            end
            if (cnt_reg >= kaddr_t'(2)) begin
                win_next = {win_reg[127:0], gen};
                if (!cnt_reg[0]) begin
                    rcon_next = xt(rcon_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        win_reg  <= win_next;
        rcon_reg <= rcon_next;
    end

endmodule

@@ design/aes_kmem.sv @@
// ----------------------------------------------------------------------------
// AES key memory
// Holds the forward and inverse round keys with a registered read port.
// ----------------------------------------------------------------------------
module aes_kmem (
    input  logic            aclk,
    input  aes_pkg::ks_wr_t wr,
    input  logic            rd_dec,
    input  aes_pkg::kaddr_t rd_addr,
    output aes_pkg::blk_t   rd_data
);
    import aes_pkg::*;

    blk_t enc_mem [ROUNDS+1];
    blk_t dec_mem [ROUNDS+1];
    blk_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            enc_mem[wr.enc_addr] <= wr.enc_key;
            dec_mem[wr.dec_addr] <= wr.dec_key;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= rd_dec ? dec_mem[rd_addr] : enc_mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

@@ design/aes256_cbc_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// AES-256 CBC block cipher
// Encrypts or decrypts 128-bit blocks in CBC mode with a 256-bit key.
// ----------------------------------------------------------------------------
// Usage: the key, IV and mode are written through the cfg_we, cfg_index and
// cfg_wdata port while the block is idle. Blocks enter on the s_ channel and
// results leave on the m_ channel, both with valid and ready.
// A request is taken only when the engine is idle. The rounds share one round
// unit and read their keys from a key memory with a registered read. A block
// passes from acceptance to a valid result through the fetch state, fifteen
// key additions and rounds, and the done state that loads the output.
// A new block can enter only once the engine is back in its idle state.
// After a key write the first block also waits in the schedule state while the
// key scheduler writes one round key per cycle into the memory.
// The output register lets the next request enter while a result waits; a
// stalled receiver holds the result and the engine waits in its final state.
// Reset clears the configuration registers and the chain, and marks the key
// schedule as stale so that it is rebuilt before the first block.
// ----------------------------------------------------------------------------
module aes256_cbc_block_cipher_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aes_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  aes_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output aes_pkg::out_item_t            m_data
);
    import aes_pkg::*;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [63:0] iv_hi_reg, iv_lo_reg;
    logic        mode_reg;
    logic        sched_ok_reg;
    logic        restart_reg;
    blk_t        chain_reg;
    blk_t        blk_reg;
    blk_t        st_reg;
    logic        fin_reg;
    logic        dec_reg;
    kaddr_t      round_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    ctrl_state_t state_reg, state_next;

    ks_wr_t      ks_wr;
    logic        ks_done;
    logic        ks_start;
    kaddr_t      rd_addr;
    blk_t        rd_key;
    logic        accept;
    logic        out_free;
    blk_t        res;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign res      = dec_reg ? (st_reg ^ chain_reg) : st_reg;

    aes_ksched u_ksched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ks_start),
        .key     ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .wr      (ks_wr),
        .done    (ks_done)
    );

    aes_kmem u_kmem (
        .aclk    (aclk),
        .wr      (ks_wr),
        .rd_dec  (dec_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_key)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = sched_ok_reg ? ST_FETCH : ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (ks_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_ROUND;
            ST_ROUND: begin
                if (round_reg == kaddr_t'(ROUNDS)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        ks_start = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ks_start = s_valid && !sched_ok_reg;
            end
            ST_ROUND: rd_addr = round_reg + kaddr_t'(1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
            iv_hi_reg    <= '0;
            iv_lo_reg    <= '0;
            mode_reg     <= 1'b0;
            sched_ok_reg <= 1'b0;
            restart_reg  <= 1'b1;
            chain_reg    <= '0;
            round_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_KEY0: begin
                        key0_reg     <= cfg_wdata;
                        sched_ok_reg <= 1'b0;
                    end
                    REG_KEY1: begin
                        key1_reg     <= cfg_wdata;
                        sched_ok_reg <= 1'b0;
                    end
                    REG_KEY2: begin
                        key2_reg     <= cfg_wdata;
                        sched_ok_reg <= 1'b0;
                    end
                    REG_KEY3: begin
                        key3_reg     <= cfg_wdata;
                        sched_ok_reg <= 1'b0;
                    end
                    REG_IV_HI:  iv_hi_reg <= cfg_wdata;
                    REG_IV_LO:  iv_lo_reg <= cfg_wdata;
                    REG_MODE:   mode_reg  <= cfg_wdata[0];
                    REG_UNUSED: mode_reg  <= mode_reg;
                    default:    mode_reg  <= mode_reg;
                endcase
            end
            if (ks_done) begin
                sched_ok_reg <= 1'b1;
            end
            if (accept && restart_reg) begin
                chain_reg <= {iv_hi_reg, iv_lo_reg};
            end
            if (state_reg == ST_FETCH) begin
                round_reg <= '0;
            end else if (state_reg == ST_ROUND) begin
                round_reg <= round_reg + kaddr_t'(1);
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                chain_reg   <= dec_reg ? blk_reg : st_reg;
                restart_reg <= fin_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            blk_reg <= {s_data.block_high, s_data.block_low};
            fin_reg <= s_data.final_block;
            dec_reg <= mode_reg;
        end
        if (state_reg == ST_ROUND) begin
            if (round_reg == kaddr_t'(0)) begin
                st_reg <= (dec_reg ? blk_reg : (blk_reg ^ chain_reg)) ^ rd_key;
            end else begin
                st_reg <= round_fn(st_reg, dec_reg, round_reg == kaddr_t'(ROUNDS)) ^ rd_key;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.result_high <= res[127:64];
            m_data_reg.result_low  <= res[63:0];
            m_data_reg.final_out   <= fin_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/aes_chk.sv @@
// ----------------------------------------------------------------------------
// AES port checker
// Watches the channels of the AES-256 CBC block for ordering slips.
// ----------------------------------------------------------------------------
module aes_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input aes_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed or dropped.");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second request taken while a block was in progress.");

    a_no_early_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_valid && s_ready))
        else $error("Result appeared directly after a request.");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

endmodule

bind aes256_cbc_block_cipher_top aes_chk u_aes_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/aes256_cbc_checker.sv @@
// ----------------------------------------------------------------------------
// AES-256 CBC result checker
// Watches the request and result channels, predicts each result with its own
// AES-256 CBC cipher model and compares every result field by field.
// ----------------------------------------------------------------------------
module aes256_cbc_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  aes_pkg::in_item_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  aes_pkg::out_item_t m_data,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    logic [7:0]   fwd_sub [256];
    logic [7:0]   rev_sub [256];
    logic [63:0]  key_regs [4];
    logic [127:0] iv_reg;
    logic         mode_dec;
    logic [127:0] chain;
    logic         restart;
    logic [127:0] enc_keys [15];
    logic [127:0] dec_keys [15];
    out_item_t    expected_q [$];

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = gf_dbl(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] byte_of(input logic [127:0] s, input int k);
        return s[127-8*k -: 8];
    endfunction

    function automatic logic [127:0] columns_mix(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] m [4];
        for (int c = 0; c < 4; c++) begin
            a0 = byte_of(s, 4*c);
            a1 = byte_of(s, 4*c+1);
            a2 = byte_of(s, 4*c+2);
            a3 = byte_of(s, 4*c+3);
            if (inv) begin
                m[0] = gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9);
                m[1] = gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13);
                m[2] = gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11);
                m[3] = gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14);
            end else begin
                m[0] = gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3;
                m[1] = a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3;
                m[2] = a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3);
                m[3] = gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2);
            end
            for (int j = 0; j < 4; j++) r[127-8*(4*c+j) -: 8] = m[j];
        end
        return r;
    endfunction

    function automatic void expand_keys();
        logic [7:0] w [240];
        logic [7:0] t [4];
        logic [7:0] t0;
        logic [7:0] rc;
        logic [127:0] ek;
        rc = 8'h01;
        for (int i = 0; i < 32; i++) w[i] = key_regs[i/8][63-8*(i%8) -: 8];
        for (int i = 8; i < 60; i++) begin
            for (int k = 0; k < 4; k++) t[k] = w[4*(i-1)+k];
            if (i % 8 == 0) begin
                t0 = t[0];
                t[0] = fwd_sub[t[1]] ^ rc;
                t[1] = fwd_sub[t[2]];
                t[2] = fwd_sub[t[3]];
                t[3] = fwd_sub[t0];
                rc = gf_dbl(rc);
            end else if (i % 8 == 4) begin
                for (int k = 0; k < 4; k++) t[k] = fwd_sub[t[k]];
            end
            for (int k = 0; k < 4; k++) w[4*i+k] = w[4*(i-8)+k] ^ t[k];
        end
        for (int r = 0; r <= ROUNDS; r++) begin
            for (int k = 0; k < 16; k++) ek[127-8*k -: 8] = w[16*r+k];
            enc_keys[r] = ek;
        end
        for (int r = 0; r <= ROUNDS; r++) begin
            dec_keys[r] = (r == 0 || r == ROUNDS) ? enc_keys[ROUNDS-r]
                                                  : columns_mix(enc_keys[ROUNDS-r], 1'b1);
        end
    endfunction

    function automatic logic [127:0] cipher_rounds(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        s ^= inv ? dec_keys[0] : enc_keys[0];
        for (int r = 1; r <= ROUNDS; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 4; j++) begin
                    t[127-8*(4*c+j) -: 8] = inv ? rev_sub[byte_of(s, 4*((c-j+4)%4)+j)]
                                                : fwd_sub[byte_of(s, 4*((c+j)%4)+j)];
                end
            end
            s = (r != ROUNDS) ? columns_mix(t, inv) : t;
            s ^= inv ? dec_keys[r] : enc_keys[r];
        end
        return s;
    endfunction

    function automatic out_item_t cbc_predict(input in_item_t req);
        out_item_t res;
        logic [127:0] blk;
        logic [127:0] o;
        blk = {req.block_high, req.block_low};
        if (restart) chain = iv_reg;
        if (mode_dec) begin
            o = cipher_rounds(blk, 1'b1) ^ chain;
            chain = blk;
        end else begin
            o = cipher_rounds(blk ^ chain, 1'b0);
            chain = o;
        end
        res.result_high = o[127:64];
        res.result_low  = o[63:0];
        res.final_out   = req.final_block;
        restart = req.final_block;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    bit schedule_stale;

    initial begin
        for (int i = 0; i < 256; i++) begin
            fwd_sub[i] = 8'(SBOX_TABLE >> (8*(255-i)));
        end
        for (int i = 0; i < 256; i++) rev_sub[fwd_sub[i]] = 8'(i);
        fail_count = 0;
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_regs[i] = '0;
            iv_reg = '0;
            mode_dec = 1'b0;
            chain = '0;
            restart = 1'b1;
            schedule_stale = 1'b1;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                        key_regs[cfg_index[1:0]] = cfg_wdata;
                        schedule_stale = 1'b1;
                    end
                    REG_IV_HI: iv_reg[127:64] = cfg_wdata;
                    REG_IV_LO: iv_reg[63:0] = cfg_wdata;
                    REG_MODE: mode_dec = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (schedule_stale) begin
                    expand_keys();
                    schedule_stale = 1'b0;
                end
                expected_q.push_back(cbc_predict(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_data.result_high, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.result_high !== want.result_high)
                        report_mismatch("result_high", m_data.result_high, want.result_high);
                    if (m_data.result_low !== want.result_low)
                        report_mismatch("result_low", m_data.result_low, want.result_low);
                    if (m_data.final_out !== want.final_out)
                        report_mismatch("final_out", 64'(m_data.final_out),
                                        64'(want.final_out));
                end
            end
        end
    end

endmodule

@@ test/tb_aes256_cbc_block_cipher_top.sv @@
// ----------------------------------------------------------------------------
// AES-256 CBC block cipher testbench
// Drives keys, IVs and modes through the configuration port and sends blocks
// as directed and random CBC messages with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_aes256_cbc_block_cipher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    int                 fail_count;
    int                 pending;
    longint             cycle_count;

    localparam longint CYCLE_LIMIT = 400000;

    aes256_cbc_block_cipher_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    aes256_cbc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic fin);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{block_high: hi, block_low: lo, final_block: fin};
        @(posedge aclk iff s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (25) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic load_setting(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] ivh, input logic [63:0] ivl,
                                input logic [63:0] md);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_IV_HI, ivh);
        write_reg(REG_IV_LO, ivl);
        write_reg(REG_MODE, md);
    endtask

    initial begin
        int sent;
        int len;
        cycle_count = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: zero key, zero IV, encrypt.
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b1);
        settle();
        load_setting('1, '1, '1, '1, '1, '1, 64'd1);
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        settle();
        // Mode change mid-message keeps the chain; IV write waits for restart.
        write_reg(REG_MODE, 64'hffff_ffff_ffff_fffe);
        write_reg(REG_IV_HI, 64'h0011_2233_4455_6677);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
        settle();
        write_reg(REG_UNUSED, '1);
        load_setting(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                     64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f, '0, '0, '0);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1);
        settle();
        write_reg(REG_MODE, 64'd1);
        send_block(64'h8ea2_b7ca_5167_45bf, 64'hEAFC_4990_4B49_6089, 1'b1);
        settle();

        sent = 0;
        while (sent < 640) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_KEY0, rand64());
                write_reg(REG_KEY1, rand64());
                write_reg(REG_KEY2, rand64());
                write_reg(REG_KEY3, rand64());
            end
            write_reg(REG_IV_HI, rand64());
            write_reg(REG_IV_LO, rand64());
            write_reg(REG_MODE, 64'($urandom_range(0, 3)));
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                send_block(rand64(), rand64(), (i == len - 1) ? 1'b1 : 1'($urandom()));
                sent++;
            end
            settle();
        end
        settle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
